// File: rtl/led_matrix_chain_refresh_assert.svh
// Assertion macros used by the chain refresh sequencer.
`ifndef LED_MATRIX_CHAIN_REFRESH_ASSERT_SVH
`define LED_MATRIX_CHAIN_REFRESH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LMCR_ASSERT_NOW(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMCR_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: rtl/lmcr_pkg.sv
// Types, codes and constant tables of the LED matrix chain refresh block.
package lmcr_pkg;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_GLYPH   = 2'd1,
        OP_DIGIT   = 2'd2,
        OP_REFRESH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_INIT,
        ST_RD,
        ST_EMIT
    } seq_state_t;

    localparam logic CFG_INTENSITY  = 1'b0;
    localparam logic CFG_SCAN_LIMIT = 1'b1;

    localparam logic [3:0] ADDR_DECODE   = 4'h9;
    localparam logic [3:0] ADDR_INTENS   = 4'hA;
    localparam logic [3:0] ADDR_SCAN     = 4'hB;
    localparam logic [3:0] ADDR_SHUTDOWN = 4'hC;
    localparam logic [3:0] ADDR_TEST     = 4'hF;

    localparam logic [2:0] INIT_LAST_FRAME = 3'd4;
    localparam logic [3:0] DIGIT_MAX       = 4'd9;
    localparam logic [3:0] INTENS_RESET    = 4'd1;
    localparam logic [2:0] SCAN_RESET      = 3'd7;

    // Frame store access, one request per cycle.
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic       clear;
        logic [2:0] row;
        logic [2:0] module_sel;
        logic [7:0] wr_data;
    } store_req_t;

    // One chain word headed for the output register.
    typedef struct packed {
        logic       valid;
        logic [3:0] reg_addr;
        logic [7:0] reg_data;
        logic       frame_end;
        logic       last;
    } out_word_t;

    // Digit glyphs, row 0 first; codes above nine read as blank.
    localparam logic [7:0] DIGIT_GLYPHS [16][8] = '{
        '{8'h3C, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h66, 8'h38},
        '{8'h38, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h18},
        '{8'h7C, 8'h42, 8'h02, 8'h04, 8'h08, 8'h30, 8'h42, 8'h7E},
        '{8'h7C, 8'h46, 8'h04, 8'h18, 8'h06, 8'h02, 8'h42, 8'h3C},
        '{8'h0C, 8'h14, 8'h14, 8'h24, 8'h44, 8'h3C, 8'h04, 8'h0C},
        '{8'h3E, 8'h40, 8'h58, 8'h64, 8'h02, 8'h02, 8'h42, 8'h3C},
        '{8'h3E, 8'h40, 8'h40, 8'h7C, 8'h42, 8'h42, 8'h42, 8'h3C},
        '{8'h7E, 8'h04, 8'h04, 8'h08, 8'h10, 8'h10, 8'h10, 8'h10},
        '{8'h7C, 8'h42, 8'h62, 8'h3C, 8'h44, 8'h42, 8'h42, 8'h3C},
        '{8'h7C, 8'h42, 8'h42, 8'h46, 8'h3A, 8'h02, 8'h44, 8'h38},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    function automatic logic [7:0] digit_row(input logic [3:0] dig, input logic [2:0] row);
        return DIGIT_GLYPHS[dig][row];
    endfunction

    function automatic logic [11:0] init_word(input logic [2:0] frame,
                                             input logic [3:0] intens,
                                             input logic [2:0] scan);
        logic [11:0] w;
        unique case (frame)
            3'd0:    w = {8'h00, ADDR_DECODE};
            3'd1:    w = {4'h0, intens, ADDR_INTENS};
            3'd2:    w = {5'h00, scan, ADDR_SCAN};
            3'd3:    w = {8'h01, ADDR_SHUTDOWN};
            3'd4:    w = {8'h00, ADDR_TEST};
            default: w = 12'h000;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/led_matrix_chain_refresh.sv
// Top level of the LED matrix chain refresh block: ports, config and output register.
//
// Usage: commands arrive as words on the s_ stream (opcode, module index, digit,
// 64-bit glyph). Opcode 0 (init) clears the frame store and sends five broadcast
// frames of MODULES chain words each. Opcodes 1 and 2 load a glyph or a built-in
// digit into one module and give no words; a module index of MODULES or more, or
// a digit above nine, is dropped. Opcode 3 sends the current row as one frame of
// MODULES words and advances the row pointer, wrapping after row 7.
// Each m_ word carries a register address and data; tuser marks the last word of
// a frame (chip select release) and tlast the last word caused by a command.
// Per command, after accept: init sends its five frames, a load writes the eight
// rows into the store, a refresh reads and emits one word per module (store read and
// emit alternate over the single read port), an ignored load does nothing. s_tready
// is high only while the sequencer idles. A refresh word waits for its store read.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset clears the store, row pointer and output valid, and sets intensity to 1
// and scan limit to 7. Write cfg_ registers only while no command is in flight.
module led_matrix_chain_refresh #(
    parameter int MODULES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // opcode[1:0], module_index[4:2], digit[8:5],
                                   // glyph_rows[72:9], zero fill above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // reg_addr[3:0], reg_data[11:4], zero fill above
    output logic        m_tuser,   // frame_end
    output logic        m_tlast,   // last
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [3:0]  cfg_wr_data
);
    import lmcr_pkg::*;

    logic [3:0]  intensity_reg;
    logic [2:0]  scan_limit_reg;
    logic        m_valid_reg;
    logic [3:0]  addr_reg;
    logic [7:0]  data_reg;
    logic        fend_reg;
    logic        last_reg;
    logic        out_free;
    out_word_t   word;
    store_req_t  sreq;
    logic [7:0]  rd_data;

    // Configuration writes land directly; no read-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            intensity_reg  <= INTENS_RESET;
            scan_limit_reg <= SCAN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_INTENSITY:  intensity_reg  <= cfg_wr_data;
                CFG_SCAN_LIMIT: scan_limit_reg <= cfg_wr_data[2:0];
                default: ;
            endcase
        end
    end

    // Output register: free when empty or being taken this cycle.
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (word.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; load it with each new word.
    always_ff @(posedge aclk) begin
        if (word.valid) begin
            addr_reg <= word.reg_addr;
            data_reg <= word.reg_data;
            fend_reg <= word.frame_end;
            last_reg <= word.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, data_reg, addr_reg};
    assign m_tuser  = fend_reg;
    assign m_tlast  = last_reg;

    lmcr_seq #(
        .MODULES (MODULES)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .in_opcode       (s_tdata[1:0]),
        .in_module_index (s_tdata[4:2]),
        .in_digit        (s_tdata[8:5]),
        .in_glyph_rows   (s_tdata[72:9]),
        .intensity       (intensity_reg),
        .scan_limit      (scan_limit_reg),
        .out_free        (out_free),
        .word            (word),
        .sreq            (sreq),
        .rd_data         (rd_data)
    );

    lmcr_store #(
        .MODULES (MODULES)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sreq),
        .rd_data (rd_data)
    );

endmodule

// File: rtl/lmcr_store.sv
// Frame store: row bytes per module, one write or one registered read a cycle.
module lmcr_store #(
    parameter int MODULES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lmcr_pkg::store_req_t req,
    output logic [7:0]          rd_data
);
    import lmcr_pkg::*;

    localparam int MW    = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int AW    = 3 + MW;
    localparam int DEPTH = 8 << MW;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;
    logic [AW-1:0]    idx;

    assign idx = {req.row, req.module_sel[MW-1:0]};

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[idx] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[idx];
        end
    end

    // Entries not written since reset or init read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.clear) begin
                vld_reg <= '0;
            end else if (req.wr_en) begin
                vld_reg[idx] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= vld_reg[idx];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : 8'h00;

endmodule

// File: rtl/lmcr_seq.sv
// Command sequencer: init frames, glyph loads and row refresh over shared counters.
`include "led_matrix_chain_refresh_assert.svh"
module lmcr_seq #(
    parameter int MODULES = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           in_opcode,
    input  logic [2:0]           in_module_index,
    input  logic [3:0]           in_digit,
    input  logic [63:0]          in_glyph_rows,
    input  logic [3:0]           intensity,
    input  logic [2:0]           scan_limit,
    input  logic                 out_free,
    output lmcr_pkg::out_word_t  word,
    output lmcr_pkg::store_req_t sreq,
    input  logic [7:0]           rd_data
);
    import lmcr_pkg::*;

    localparam int MW = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam logic [MW-1:0] M_LAST = MW'(MODULES - 1);

    seq_state_t    state_reg, state_next;
    logic [2:0]    mod_reg, mod_next;
    logic [3:0]    digit_reg, digit_next;
    logic [63:0]   glyph_reg, glyph_next;
    logic          use_digit_reg, use_digit_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic [MW-1:0] m_reg, m_next;
    logic [2:0]    row_ptr_reg, row_ptr_next;
    logic          mod_ok;
    logic          m_end;
    logic [11:0]   iw;

    assign mod_ok = ({1'b0, in_module_index} < 4'(MODULES));
    assign m_end  = (m_reg == M_LAST);
    assign iw     = init_word(cnt_reg, intensity, scan_limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_reg       <= '0;
            row_ptr_reg <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_reg       <= m_next;
            row_ptr_reg <= row_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        mod_reg       <= mod_next;
        digit_reg     <= digit_next;
        glyph_reg     <= glyph_next;
        use_digit_reg <= use_digit_next;
    end

    always_comb begin
        state_next     = state_reg;
        mod_next       = mod_reg;
        digit_next     = digit_reg;
        glyph_next     = glyph_reg;
        use_digit_next = use_digit_reg;
        cnt_next       = cnt_reg;
        m_next         = m_reg;
        row_ptr_next   = row_ptr_reg;
        s_tready       = (state_reg == ST_IDLE);
        sreq           = '0;
        word           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mod_next       = in_module_index;
                    digit_next     = in_digit;
                    glyph_next     = in_glyph_rows;
                    use_digit_next = (in_opcode == OP_DIGIT);
                    cnt_next       = '0;
                    m_next         = '0;
                    unique case (in_opcode)
                        OP_INIT: begin
                            sreq.clear = 1'b1;
                            state_next = ST_INIT;
                        end
                        OP_GLYPH: begin
                            if (mod_ok) state_next = ST_LOAD;
                        end
                        OP_DIGIT: begin
                            if (mod_ok && in_digit <= DIGIT_MAX) state_next = ST_LOAD;
                        end
                        OP_REFRESH: begin
                            state_next = ST_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                // Write one row a cycle.
                sreq.wr_en      = 1'b1;
                sreq.row        = cnt_reg;
                sreq.module_sel = mod_reg;
                sreq.wr_data    = use_digit_reg ? digit_row(digit_reg, cnt_reg)
                                                : glyph_reg[{cnt_reg, 3'b000} +: 8];
                cnt_next        = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) state_next = ST_IDLE;
            end
            ST_INIT: begin
                if (out_free) begin
                    word.valid     = 1'b1;
                    word.reg_addr  = iw[3:0];
                    word.reg_data  = iw[11:4];
                    word.frame_end = m_end;
                    word.last      = m_end && (cnt_reg == INIT_LAST_FRAME);
                    if (m_end) begin
                        m_next   = '0;
                        cnt_next = cnt_reg + 3'd1;
                        if (cnt_reg == INIT_LAST_FRAME) state_next = ST_IDLE;
                    end else begin
                        m_next = m_reg + MW'(1);
                    end
                end
            end
            ST_RD: begin
                sreq.rd_en      = 1'b1;
                sreq.row        = row_ptr_reg;
                sreq.module_sel = 3'(m_reg);
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    word.valid     = 1'b1;
                    word.reg_addr  = {1'b0, row_ptr_reg} + 4'd1;
                    word.reg_data  = rd_data;
                    word.frame_end = m_end;
                    word.last      = m_end;
                    if (m_end) begin
                        row_ptr_next = row_ptr_reg + 3'd1;
                        state_next   = ST_IDLE;
                    end else begin
                        m_next     = m_reg + MW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `LMCR_ASSERT_NOW(a_word_needs_room, aclk, aresetn, word.valid, out_free, "word issued into a full output register")
    `LMCR_ASSERT_NOW(a_last_ends_frame, aclk, aresetn, word.valid && word.last, word.frame_end, "last word does not end a frame")
    `LMCR_ASSERT_NEXT(a_refresh_reads, aclk, aresetn, s_tvalid && s_tready && in_opcode == OP_REFRESH, state_reg == ST_RD, "refresh did not start a store read")
    `LMCR_ASSERT_NOW(a_store_one_access, aclk, aresetn, sreq.wr_en, !sreq.rd_en && !sreq.clear, "store write collides with read or clear")

endmodule

// File: tb/tb_led_matrix_chain_refresh.sv
// Self-checking testbench for the LED matrix chain refresh block.
`timescale 1ns / 100ps

module tb_led_matrix_chain_refresh;
    import lmcr_pkg::*;

    localparam int MODS           = 4;
    localparam int IDLE_LIMIT     = 1000;  // cycles with no handshake before giving up
    localparam int LOAD_SETTLE    = 24;    // covers a load still writing the store
    localparam int PHASES         = 7;
    localparam int ITEMS_PER_PHASE = 50;

    // Built-in digit glyphs, row 0 in the low byte.
    localparam logic [63:0] DIGIT_ROWS [10] = '{
        64'h3866424242424_23C,
        64'h1808080808080838,
        64'h7E4230080402427C,
        64'h3C42020618044_67C,
        64'h0C043C442414140C,
        64'h3C42020264584_03E,
        64'h3C4242427C40403E,
        64'h101010100804047E,
        64'h3C4242443C62427C,
        64'h3844023A4642427C
    };

    // One chain word as seen on the master side.
    typedef struct packed {
        logic [3:0] addr;
        logic [7:0] data;
        logic       frame_end;
        logic       last;
    } chain_word_t;

    // Tracks the frame store and row pointer, and holds the chain words still due.
    class chain_word_tracker;
        logic [7:0]  rows [8][MODS];
        logic [2:0]  row_ptr;
        logic [3:0]  intensity;
        logic [2:0]  scan_limit;
        chain_word_t words_due [$];
        int          mismatches;
        int          words_checked;

        function new();
            foreach (rows[r, m]) rows[r][m] = 8'h00;
            row_ptr       = 3'd0;
            intensity     = INTENS_RESET;
            scan_limit    = SCAN_RESET;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void write_reg(logic idx, logic [3:0] val);
            if (idx == CFG_INTENSITY) intensity = val;
            else scan_limit = val[2:0];
        endfunction

        // Broadcast one register value to every module; chip select drops on the last.
        function void push_frame(logic [3:0] addr, logic [7:0] data);
            chain_word_t w;
            for (int m = 0; m < MODS; m++) begin
                w.addr      = addr;
                w.data      = data;
                w.frame_end = (m == MODS - 1);
                w.last      = 1'b0;
                words_due.push_back(w);
            end
        endfunction

        function void note_command(op_t op, logic [2:0] mod, logic [3:0] dig,
                                   logic [63:0] glyph);
            int          first;
            chain_word_t w;
            first = words_due.size();
            case (op)
                OP_INIT: begin
                    push_frame(ADDR_DECODE, 8'h00);
                    push_frame(ADDR_INTENS, {4'h0, intensity});
                    push_frame(ADDR_SCAN, {5'h00, scan_limit});
                    push_frame(ADDR_SHUTDOWN, 8'h01);
                    push_frame(ADDR_TEST, 8'h00);
                    // Init blanks the store but keeps the row pointer.
                    foreach (rows[r, m]) rows[r][m] = 8'h00;
                end
                OP_GLYPH: begin
                    if (mod < MODS)
                        for (int r = 0; r < 8; r++) rows[r][mod] = glyph[8*r +: 8];
                end
                OP_DIGIT: begin
                    // Drop codes above nine and modules past the end of the chain.
                    if (mod < MODS && dig <= DIGIT_MAX)
                        for (int r = 0; r < 8; r++) rows[r][mod] = DIGIT_ROWS[dig][8*r +: 8];
                end
                default: begin
                    for (int m = 0; m < MODS; m++) begin
                        w.addr      = {1'b0, row_ptr} + 4'd1;
                        w.data      = rows[row_ptr][m];
                        w.frame_end = (m == MODS - 1);
                        w.last      = 1'b0;
                        words_due.push_back(w);
                    end
                    row_ptr = row_ptr + 3'd1;
                end
            endcase
            if (words_due.size() > first)
                words_due[words_due.size() - 1].last = 1'b1;
        endfunction

        function void check_word(chain_word_t got);
            chain_word_t exp;
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, got addr %h data %h",
                         $time, got.addr, got.data);
                mismatches++;
                return;
            end
            exp = words_due.pop_front();
            words_checked++;
            if (got.addr !== exp.addr) begin
                $display("%0t: reg_addr mismatch, expected %h, got %h", $time,
                         exp.addr, got.addr);
                mismatches++;
            end
            if (got.data !== exp.data) begin
                $display("%0t: reg_data mismatch, expected %h, got %h", $time,
                         exp.data, got.data);
                mismatches++;
            end
            if (got.frame_end !== exp.frame_end) begin
                $display("%0t: frame_end mismatch, expected %b, got %b", $time,
                         exp.frame_end, got.frame_end);
                mismatches++;
            end
            if (got.last !== exp.last) begin
                $display("%0t: last mismatch, expected %b, got %b", $time,
                         exp.last, got.last);
                mismatches++;
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // opcode[1:0], module_index[4:2], digit[8:5], glyph_rows[72:9]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // reg_addr[3:0], reg_data[11:4]
    logic        m_tuser;   // frame_end
    logic        m_tlast;   // last
    logic        cfg_wr_en;
    logic        cfg_wr_index;
    logic [3:0]  cfg_wr_data;

    chain_word_tracker tracker;
    bit tx_calm;            // sender inserts no gaps while set
    bit rx_calm;            // receiver never stalls while set
    int idle_cycles;
    int op_count [4];
    int dropped_loads;
    int reg_writes;

    led_matrix_chain_refresh #(.MODULES(MODS)) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Check every word the chain side accepts against the oldest word due.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_word('{m_tdata[3:0], m_tdata[11:4], m_tuser, m_tlast});
    end

    // Give up when neither side nor the register port moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d words still due",
                         $time, IDLE_LIMIT, tracker.pending());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Receiver: draw a stall before each word, then hold ready until a word goes through.
    initial begin : receiver
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    // Send one command word; returns on the falling edge after it was taken.
    task automatic send_command(op_t op, logic [2:0] mod, logic [3:0] dig, logic [63:0] glyph);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {7'b0, glyph, dig, mod, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(op, mod, dig, glyph);
        op_count[op]++;
        if ((op == OP_GLYPH && mod >= MODS) ||
            (op == OP_DIGIT && (mod >= MODS || dig > DIGIT_MAX)))
            dropped_loads++;
        @(negedge aclk);
    endtask

    // Hold off the sender until every due word has come and a load has had time to land.
    task automatic wait_chain_quiet();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (LOAD_SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        tracker.write_reg(idx, val);
        reg_writes++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_random_command();
        int          pick;
        op_t         op;
        logic [2:0]  mod;
        logic [3:0]  dig;
        logic [63:0] glyph;
        pick = $urandom_range(0, 99);
        if (pick < 15)      op = OP_INIT;
        else if (pick < 40) op = OP_GLYPH;
        else if (pick < 65) op = OP_DIGIT;
        else                op = OP_REFRESH;
        // Mostly target real modules, sometimes a module index past the end of the chain.
        mod = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, MODS - 1))
                                         : 3'($urandom_range(MODS, 7));
        dig = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 9))
                                         : 4'($urandom_range(10, 15));
        case ($urandom_range(0, 9))
            0:       glyph = '0;
            1:       glyph = '1;
            default: glyph = {$urandom, $urandom};
        endcase
        send_command(op, mod, dig, glyph);
    endtask

    initial begin : stimulus
        int phase_mode;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = CFG_INTENSITY;
        cfg_wr_data  = '0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        dropped_loads = 0;
        reg_writes   = 0;
        foreach (op_count[i]) op_count[i] = 0;
        tracker = new();

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under reset settings: blank refresh, loads at the chain
        // edges, dropped loads, a full pointer wrap, and init keeping the pointer.
        send_command(OP_REFRESH, 3'd0, 4'd0, '0);
        send_command(OP_GLYPH, 3'd0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(OP_GLYPH, 3'(MODS - 1), 4'd0, 64'h0123_4567_89AB_CDEF);
        send_command(OP_GLYPH, 3'(MODS), 4'd0, 64'hA5A5_A5A5_A5A5_A5A5);
        send_command(OP_GLYPH, 3'd7, 4'd0, 64'h5A5A_5A5A_5A5A_5A5A);
        send_command(OP_DIGIT, 3'd1, 4'd0, '0);
        send_command(OP_DIGIT, 3'd2, 4'd9, '1);
        send_command(OP_DIGIT, 3'd1, 4'd10, '0);
        send_command(OP_DIGIT, 3'd0, 4'd15, '0);
        send_command(OP_DIGIT, 3'd6, 4'd5, '0);
        repeat (9) send_command(OP_REFRESH, 3'd0, 4'd0, '0);
        send_command(OP_INIT, 3'd7, 4'd15, '1);
        send_command(OP_REFRESH, 3'd0, 4'd0, '0);
        wait_chain_quiet();

        // Random phases, each under its own register settings and pacing.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_INTENSITY, 4'd0);
                    write_reg(CFG_SCAN_LIMIT, 4'd0);
                end
                1: begin
                    write_reg(CFG_INTENSITY, 4'd15);
                    write_reg(CFG_SCAN_LIMIT, 4'd7);
                end
                default: begin
                    write_reg(CFG_INTENSITY, 4'($urandom_range(0, 15)));
                    write_reg(CFG_SCAN_LIMIT, 4'($urandom_range(0, 7)));
                end
            endcase
            // Start with a full-speed phase and a fully throttled one.
            phase_mode = (phase == 0) ? 0 : (phase == 1) ? 3 : $urandom_range(0, 3);
            tx_calm = (phase_mode == 0 || phase_mode == 1);
            rx_calm = (phase_mode == 0 || phase_mode == 2);
            send_command(OP_INIT, 3'd0, 4'd0, '0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_random_command();
                if ($urandom_range(0, 19) == 0) wait_chain_quiet();
            end
            wait_chain_quiet();
        end

        repeat (10 * MODS) @(negedge aclk);

        $display("Ran %0d inits, %0d glyph loads, %0d digit loads, %0d refreshes",
                 op_count[OP_INIT], op_count[OP_GLYPH], op_count[OP_DIGIT],
                 op_count[OP_REFRESH]);
        $display("Checked %0d chain words (%0d loads dropped) over %0d register writes",
                 tracker.words_checked, dropped_loads, reg_writes);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d words never seen",
                     tracker.mismatches, tracker.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/lmcr_pkg.sv
rtl/lmcr_store.sv
rtl/lmcr_seq.sv
rtl/led_matrix_chain_refresh.sv
tb/tb_led_matrix_chain_refresh.sv
